FILE: sv/xtea_pkg.sv
`timescale 1ns / 1ps
package xtea_pkg;

	localparam int unsigned CYCLES_DEF = 32;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned NUM_KEYS   = 4;
	localparam int unsigned KEY_IDX_W  = 2;

	localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [NUM_KEYS-1:0][WORD_W-1:0] key_set_t;

	typedef struct packed {
		logic valid;
		logic action;
	} xtea_ctl_t;

	typedef struct packed {
		word_t first;
		word_t second;
	} xtea_blk_t;

	function automatic word_t mix_word(input word_t x);
		return ((x << 4) ^ (x >> 5)) + x;
	endfunction

endpackage

FILE: sv/xtea_block_cipher.sv
`timescale 1ns / 1ps
// XTEA block cipher, 64-bit block, 128-bit key.
// Key: four 32-bit words, reset to zero, set via wr_en / wr_index / wr_data;
// written only while the block is idle, which the block does not enforce.
// Input channel: in_valid / in_stall with action (0 encrypt, 1 decrypt),
// block_first and block_second. A transaction is taken when in_valid is high
// and in_stall is low.
// Output channel: out_valid / out_stall with result_first and result_second,
// one result per input transaction, in input order.
// Throughput: one block per cycle while in_stall is low. Each Feistel
// half-round is one cell of a chain of 2*CYCLES registered cells, followed
// by the output register.
// When the receiver stalls, one more result parks in a skid register; the
// chain then freezes and in_stall goes high until the skid entry drains.
// in_stall comes straight from a flip-flop.
// Reset clears all valid bits and the key; no result is pending afterwards.
module xtea_block_cipher import xtea_pkg::*; #(
	parameter int unsigned CYCLES = CYCLES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [KEY_IDX_W-1:0] wr_index,
	input  logic [WORD_W-1:0]    wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 action,
	input  logic [WORD_W-1:0]    block_first,
	input  logic [WORD_W-1:0]    block_second,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WORD_W-1:0]    result_first,
	output logic [WORD_W-1:0]    result_second
);

	localparam int unsigned STAGES = 2 * CYCLES;

	key_set_t  key_q;
	logic      en;
	xtea_ctl_t ctl [STAGES+1];
	xtea_blk_t blk [STAGES+1];
	xtea_blk_t out_blk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (wr_en) begin
			key_q[wr_index] <= wr_data;
		end
	end

	assign in_stall = !en;
	assign ctl[0]   = '{valid: in_valid, action: action};
	assign blk[0]   = '{first: block_first, second: block_second};

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		xtea_cell #(
			.CYCLES(CYCLES),
			.STAGE (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (ctl[i]),
			.blk_in (blk[i]),
			.key    (key_q),
			.ctl_out(ctl[i+1]),
			.blk_out(blk[i+1])
		);
	end

	xtea_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (ctl[STAGES].valid),
		.blk_in   (blk[STAGES]),
		.out_stall(out_stall),
		.en       (en),
		.out_valid(out_valid),
		.out_blk  (out_blk)
	);

	assign result_first  = out_blk.first;
	assign result_second = out_blk.second;

endmodule

FILE: sv/xtea_cell.sv
`timescale 1ns / 1ps
module xtea_cell import xtea_pkg::*; #(
	parameter int unsigned CYCLES = CYCLES_DEF,
	parameter int unsigned STAGE  = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  xtea_ctl_t ctl_in,
	input  xtea_blk_t blk_in,
	input  key_set_t  key,
	output xtea_ctl_t ctl_out,
	output xtea_blk_t blk_out
);

	localparam bit          ODD = (STAGE % 2) == 1;
	localparam int unsigned NE  = STAGE / 2 + STAGE % 2;
	localparam int unsigned ND  = CYCLES - NE;

	localparam word_t SUM_ENC = WORD_W'(64'(XTEA_DELTA) * 64'(NE));
	localparam word_t SUM_DEC = WORD_W'(64'(XTEA_DELTA) * 64'(ND));

	// first-half updates pick the key by sum[1:0], second-half ones by sum[12:11]
	localparam logic [KEY_IDX_W-1:0] KE = ODD ? SUM_ENC[12:11] : SUM_ENC[1:0];
	localparam logic [KEY_IDX_W-1:0] KD = ODD ? SUM_DEC[1:0] : SUM_DEC[12:11];

	logic      upd_x;
	word_t     src;
	word_t     dst;
	word_t     tweak;
	word_t     f;
	word_t     res;
	xtea_blk_t nxt;
	logic      vld_s1;
	logic      action_s1;
	xtea_blk_t blk_s1;

	always_comb begin
		// encryption starts on the first half, decryption on the second
		upd_x = ~(ctl_in.action ^ 1'(ODD));
		src   = upd_x ? blk_in.second : blk_in.first;
		dst   = upd_x ? blk_in.first : blk_in.second;
		tweak = ctl_in.action ? (SUM_DEC + key[KD]) : (SUM_ENC + key[KE]);
		f     = mix_word(src) ^ tweak;
		res   = ctl_in.action ? (dst - f) : (dst + f);
		nxt.first  = upd_x ? res : blk_in.first;
		nxt.second = upd_x ? blk_in.second : res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			action_s1 <= ctl_in.action;
			blk_s1    <= nxt;
		end
	end

	assign ctl_out = '{valid: vld_s1, action: action_s1};
	assign blk_out = blk_s1;

endmodule

FILE: sv/xtea_skid.sv
`timescale 1ns / 1ps
module xtea_skid import xtea_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      vld_in,
	input  xtea_blk_t blk_in,
	input  logic      out_stall,
	output logic      en,
	output logic      out_valid,
	output xtea_blk_t out_blk
);

	logic      out_vld_q;
	logic      skid_vld_q;
	xtea_blk_t out_blk_q;
	xtea_blk_t skid_blk_q;
	logic      out_ready;

	assign out_ready = !out_vld_q || !out_stall;
	// freeze the chain only while the skid entry is occupied
	assign en        = !skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_ready) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end
		end else if (vld_in) begin
			if (out_ready) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_ready) begin
				out_blk_q <= skid_blk_q;
			end
		end else if (vld_in) begin
			if (out_ready) begin
				out_blk_q <= blk_in;
			end else begin
				skid_blk_q <= blk_in;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_blk   = out_blk_q;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry held without a pending output transaction");

	a_park_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		vld_in && !skid_vld_q && out_vld_q && out_stall |=> skid_vld_q)
		else $error("arriving transaction not parked while output stalled");

	a_drain_skid: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && !out_stall |=> !skid_vld_q && out_vld_q)
		else $error("skid entry not drained when output was taken");

	a_chain_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && vld_in |=> $stable(blk_in))
		else $error("chain advanced while skid entry occupied");

endmodule

FILE: tb/xtea_block_cipher_test.sv
`timescale 1ns / 1ps
module xtea_block_cipher_test;
	import xtea_pkg::*;

	localparam int unsigned ROUNDS      = CYCLES_DEF;
	localparam logic        ACT_ENCRYPT = 1'b0;
	localparam logic        ACT_DECRYPT = 1'b1;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          LONG_HOLD   = 250;
	localparam int          DRAIN_WAIT  = 2 * ROUNDS + 16;
	localparam int          STALL_NONE  = 0;
	localparam int          STALL_LIGHT = 1;
	localparam int          STALL_HEAVY = 2;

	typedef struct {
		logic  act;
		word_t first;
		word_t second;
	} block_req_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  wr_en = 1'b0;
	logic  [KEY_IDX_W-1:0] wr_index = '0;
	word_t wr_data = '0;
	logic  in_valid = 1'b0;
	logic  in_stall;
	logic  action = 1'b0;
	word_t block_first = '0;
	word_t block_second = '0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	word_t result_first;
	word_t result_second;

	word_t      key_words [NUM_KEYS];
	block_req_t pending_blocks[$];
	xtea_blk_t  expected_blocks[$];
	block_req_t next_req;
	xtea_blk_t  got_blk;
	xtea_blk_t  exp_blk;
	int         mismatch_count = 0;
	int         cycle_count = 0;
	int         burst_left = 0;
	int         gap_left = 0;
	int         results_taken = 0;
	int         hold_left = 0;
	int         hold_idx = 0;
	int         hold_points [2] = '{60, 250};
	int         stall_mode = STALL_NONE;
	int         mode_left = 0;

	xtea_block_cipher dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.block_first  (block_first),
		.block_second (block_second),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_first (result_first),
		.result_second(result_second)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic word_t feistel_mix(input word_t v);
		return ((v << 4) ^ (v >> 5)) + v;
	endfunction

	function automatic xtea_blk_t xtea_transform(input logic act, input word_t a, input word_t b);
		word_t     x;
		word_t     y;
		word_t     s;
		xtea_blk_t r;
		x = a;
		y = b;
		s = '0;
		if (act == ACT_ENCRYPT) begin
			for (int n = 0; n < ROUNDS; n++) begin
				x = x + (feistel_mix(y) ^ (s + key_words[s[1:0]]));
				s = s + XTEA_DELTA;
				y = y + (feistel_mix(x) ^ (s + key_words[s[12:11]]));
			end
		end else begin
			// start from delta times the round count, wrapped to 32 bits
			for (int n = 0; n < ROUNDS; n++)
				s = s + XTEA_DELTA;
			for (int n = 0; n < ROUNDS; n++) begin
				y = y - (feistel_mix(x) ^ (s + key_words[s[12:11]]));
				s = s - XTEA_DELTA;
				x = x - (feistel_mix(y) ^ (s + key_words[s[1:0]]));
			end
		end
		r.first = x;
		r.second = y;
		return r;
	endfunction

	task automatic queue_block(input logic act, input word_t a, input word_t b);
		block_req_t req;
		req.act = act;
		req.first = a;
		req.second = b;
		pending_blocks.push_back(req);
	endtask

	// encrypt a block, then decrypt the ciphertext it should give
	task automatic queue_roundtrip(input word_t a, input word_t b);
		xtea_blk_t c;
		c = xtea_transform(ACT_ENCRYPT, a, b);
		queue_block(ACT_ENCRYPT, a, b);
		queue_block(ACT_DECRYPT, c.first, c.second);
	endtask

	function automatic word_t pick_word();
		if ($urandom_range(0, 9) != 0)
			return $urandom;
		case ($urandom_range(0, 3))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			default: return 32'h7FFF_FFFF;
		endcase
	endfunction

	task automatic queue_random(input int count);
		int made;
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 6) == 0) begin
				queue_roundtrip(pick_word(), pick_word());
				made += 2;
			end else begin
				queue_block($urandom_range(0, 1) ? ACT_DECRYPT : ACT_ENCRYPT,
					pick_word(), pick_word());
				made++;
			end
		end
	endtask

	task automatic load_key(input word_t k0, input word_t k1, input word_t k2, input word_t k3);
		word_t kw [NUM_KEYS];
		kw[0] = k0;
		kw[1] = k1;
		kw[2] = k2;
		kw[3] = k3;
		for (int i = 0; i < NUM_KEYS; i++) begin
			@(posedge clk);
			wr_en <= 1'b1;
			wr_index <= i[KEY_IDX_W-1:0];
			wr_data <= kw[i];
			key_words[i] = kw[i];
		end
		@(posedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// hold until the block has nothing left in flight
	task automatic wait_idle();
		@(negedge clk);
		while (pending_blocks.size() != 0 || in_valid || expected_blocks.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic report_mismatch(input string what, input word_t exp_v, input word_t got_v);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s: expected %08h, got %08h", what, exp_v, got_v);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_blocks.push_back(xtea_transform(action, block_first, block_second));
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_blocks.size() != 0) begin
					next_req = pending_blocks.pop_front();
					action <= next_req.act;
					block_first <= next_req.first;
					block_second <= next_req.second;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_blk.first = result_first;
			got_blk.second = result_second;
			if (expected_blocks.size() == 0) begin
				report_mismatch("unexpected transaction", '0, result_first);
			end else begin
				exp_blk = expected_blocks.pop_front();
				if (got_blk.first !== exp_blk.first)
					report_mismatch("result_first", exp_blk.first, got_blk.first);
				if (got_blk.second !== exp_blk.second)
					report_mismatch("result_second", exp_blk.second, got_blk.second);
			end
		end
	end

	// receiver back-pressure, with long hold-offs so the pipeline fills
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				results_taken++;
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_idx < 2 && results_taken >= hold_points[hold_idx]) begin
				hold_idx++;
				hold_left = LONG_HOLD;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
					mode_left = $urandom_range(16, 96);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					STALL_NONE: out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("xtea_block_cipher: mismatch");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NUM_KEYS; i++)
			key_words[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// all-zero key straight out of reset
		queue_block(ACT_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
		queue_block(ACT_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_block(ACT_DECRYPT, 32'h0000_0000, 32'h0000_0000);
		queue_block(ACT_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_block(ACT_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_block(ACT_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_block(ACT_ENCRYPT, 32'h8000_0000, 32'h7FFF_FFFF);
		queue_block(ACT_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
		queue_roundtrip(32'h0123_4567, 32'h89AB_CDEF);
		wait_idle();

		load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_block(ACT_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
		queue_block(ACT_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_roundtrip(32'h0000_0000, 32'hFFFF_FFFF);
		wait_idle();

		load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
		queue_block(ACT_ENCRYPT, 32'h4142_4344, 32'h4546_4748);
		queue_block(ACT_DECRYPT, 32'h4142_4344, 32'h4546_4748);
		queue_roundtrip(32'hDEAD_BEEF, 32'h0123_4567);
		wait_idle();

		load_key($urandom, $urandom, $urandom, $urandom);
		queue_random(200);
		wait_idle();

		load_key(32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'h8000_0000);
		queue_random(200);
		wait_idle();

		load_key($urandom, $urandom, $urandom, $urandom);
		queue_random(200);
		wait_idle();

		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("xtea_block_cipher: match");
		end else begin
			$display("xtea_block_cipher: mismatch");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/xtea_pkg.sv
sv/xtea_cell.sv
sv/xtea_skid.sv
sv/xtea_block_cipher.sv
tb/xtea_block_cipher_test.sv
